/* sv/jpc_pkg.sv */
// shared constants, types and codes for the joystick poll conditioner
package jpc_pkg;

    localparam int BUTTON_COUNT_DEF = 32;
    localparam int AXIS_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF    = 15;

    localparam int LANE_W  = 16;
    localparam int OUT_W   = 16;
    localparam int DZ_W    = 15;
    localparam int KIND_W  = 2;
    localparam int BTN_W   = 5;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 64;

    // divider quotient width; the dividend is twice as wide less one bit
    localparam int DIV_W   = 17;

    localparam logic [KIND_W-1:0] KIND_AXES    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [CFG_AW-1:0] REG_MINS     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAXS     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DZ       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_THROTTLE = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RUDDER   = 3'd4;

    // axis kinds for the per-axis post processing
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] AX_R = 2'd3;

    // start request to the shared serial divider
    typedef struct packed {
        logic               start;
        logic [2*DIV_W-2:0] num;
        logic [DIV_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

/* sv/jpc_div.sv */
// restoring bit-serial divider, one quotient bit per cycle
module jpc_div
    import jpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int W = DIV_W;

    logic [W-1:0]          r_quo, n_quo;
    logic [W-1:0]          r_rem, n_rem;
    logic [W-1:0]          r_den;
    logic [$clog2(W+1)-1:0] r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [W:0]            w_trial;

    // the quotient fits W bits, so the upper dividend bits start as the remainder
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[W-1]};
        if (i_req.start) begin
            n_quo  = i_req.num[W-1:0];
            n_rem  = {1'b0, i_req.num[2*W-2:W]};
            n_cnt  = ($clog2(W+1))'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem    = W'(w_trial - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_trial[W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

/* sv/joystick_poll_conditioner.sv */
// joystick poll conditioner top level: axis sequencer, serial divider, button scan
//
//  channel  | dir | handshake         | contents
//  s_axis   | in  | tvalid/tready     | sample: read_ok, positions, buttons
//  m_axis   | out | tvalid/tready     | axis result or button event, tlast per sample
//  cfg      | in  | i_cfg_we          | axis_mins, axis_maxs, dead_zone, has_*
//
// a converted axis passes setup, normalize division, dead-zone step, second division
// and result step; throttle skips the second division, a saturated position the
// first, an absent axis or a zero span both; after the axes the buttons are scanned
// up to the highest changed one; a failed read gives its result in the cycle after accept
// results wait in the output register under backpressure, a new sample is taken
// only once the last result left; synchronous reset clears sequencer and buttons
module joystick_poll_conditioner
    import jpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int AXIS_BITS    = AXIS_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // read_ok[0], x_pos[16:1], y_pos[32:17], z_pos[48:33], r_pos[64:49],
    // button_bits[96:65], zero pad to 104
    input  logic [103:0]        s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // x_out[15:0], y_out[31:16], throttle_out[47:32], rudder_out[63:48],
    // button_number[68:64], zero pad to 72
    output logic [71:0]         m_axis_tdata,
    // event_kind[1:0]
    output logic [KIND_W-1:0]   m_axis_tuser,
    output logic                m_axis_tlast,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    localparam logic [16:0] ONE  = 17'(1) << FRAC_BITS;
    localparam logic [16:0] ONEM = ONE - 17'd1;
    localparam int BI_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SETUP = 8'b00000010,
        S_DIV1  = 8'b00000100,
        S_DZ    = 8'b00001000,
        S_DIV2  = 8'b00010000,
        S_AXOUT = 8'b00100000,
        S_SCAN  = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DW-1:0] r_mins, r_maxs;
    logic [DZ_W-1:0]   r_dz;
    logic              r_has_t, r_has_r;
    logic [31:0]       r_prev;

    logic [31:0]       r_btn;
    logic [4*LANE_W-1:0] r_pos;
    logic [1:0]        r_ax;
    logic [OUT_W-1:0]  r_res [4];
    logic              r_neg;
    logic [16:0]       r_mag;
    logic [BI_W-1:0]   r_bi;

    logic              r_ov, r_olast;
    logic [KIND_W-1:0] r_okind;
    logic [71:0]       r_odata;

    t_div_req w_req;
    t_div_rsp w_rsp;

    jpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // setup: lane select for the current axis
    logic [AXIS_BITS-1:0] w_p, w_mn, w_mx;
    logic signed [17:0]   w_num, w_den, w_an, w_ad;
    logic [16:0]          w_dzf;
    logic [16:0]          w_v_sat;

    always_comb begin
        w_p   = r_pos[r_ax*LANE_W +: AXIS_BITS];
        w_mn  = r_mins[r_ax*LANE_W +: AXIS_BITS];
        w_mx  = r_maxs[r_ax*LANE_W +: AXIS_BITS];
        w_num = $signed({2'b00, 16'(w_p)}) - $signed({2'b00, 16'(w_mn)});
        w_den = $signed({2'b00, 16'(w_mx)}) - $signed({2'b00, 16'(w_mn)});
        w_an  = w_den[17] ? -w_num : w_num;
        w_ad  = w_den[17] ? -w_den : w_den;
        w_dzf = 17'(r_dz >> (DZ_W - FRAC_BITS));
        w_v_sat = w_rsp.quo;
    end

    logic        w_out_free;
    logic [31:0] w_cur_m;
    logic        w_bchg, w_bnow;
    logic        w_axis_on;

    assign w_out_free = !r_ov || m_axis_tready;
    assign w_cur_m = r_btn & ((BUTTON_COUNT >= 32) ? 32'hFFFF_FFFF
                                                   : ((32'd1 << BUTTON_COUNT) - 32'd1));
    assign w_bnow  = r_btn[r_bi];
    assign w_bchg  = w_bnow != r_prev[r_bi];
    assign w_axis_on = (r_ax == AX_X) || (r_ax == AX_Y) ||
                       ((r_ax == AX_Z) && r_has_t) || ((r_ax == AX_R) && r_has_r);

    // any change at a higher button index still to come
    logic [31:0] w_diff, w_above;
    logic        w_more;
    assign w_diff  = (w_cur_m ^ r_prev);
    assign w_above = w_diff & ~((32'd2 << r_bi) - 32'd1);
    assign w_more  = |w_above;

    // any button change at all, used when leaving the axis result
    logic w_more_start;
    assign w_more_start = |w_diff;

    // output register load: failed read, axis result or a button event
    logic w_load;
    assign w_load = (r_state == S_IDLE && s_axis_tvalid && !r_ov && !s_axis_tdata[0]) ||
                    (r_state == S_EMIT && w_out_free) ||
                    (r_state == S_SCAN && w_out_free && w_bchg);

    // signed value after the normalize division: quo - ONE, where quo in [0, 2*ONE)
    logic signed [17:0] w_v;
    logic [16:0]        w_absv;
    assign w_v    = $signed({1'b0, w_rsp.quo}) - $signed({1'b0, ONE});
    assign w_absv = w_v[17] ? 17'(-w_v) : 17'(w_v);

    always_comb begin
        n_state = r_state;
        w_req   = '0;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && !r_ov && s_axis_tdata[0]) n_state = S_SETUP;
            S_SETUP: begin
                if (!w_axis_on || w_den == 0) begin
                    n_state = S_AXOUT;
                end else if (w_an <= 0 || w_an >= w_ad) begin
                    n_state = S_DZ;
                end else begin
                    w_req.start = 1'b1;
                    w_req.num   = (2*DIV_W-1)'(w_an) << (FRAC_BITS + 1);
                    w_req.den   = 17'(w_ad);
                    n_state = S_DIV1;
                end
            end
            S_DIV1: if (w_rsp.done) n_state = S_DZ;
            S_DZ: begin
                if (r_ax == AX_Z || r_mag < w_dzf) begin
                    n_state = S_AXOUT;
                end else begin
                    w_req.start = 1'b1;
                    w_req.num   = (2*DIV_W-1)'(r_mag - w_dzf) << FRAC_BITS;
                    w_req.den   = ONE - w_dzf;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: if (w_rsp.done) n_state = S_AXOUT;
            S_AXOUT: n_state = (r_ax == AX_R) ? S_EMIT : S_SETUP;
            S_EMIT: if (w_out_free) n_state = w_more_start ? S_SCAN : S_IDLE;
            S_SCAN: if (w_out_free) n_state = w_more ? S_SCAN : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic signed [17:0] w_dz_res;
    always_comb begin
        w_dz_res = r_neg ? -$signed({1'b0, w_v_sat})
                         : ((w_v_sat >= ONE) ? $signed({1'b0, ONEM})
                                             : $signed({1'b0, w_v_sat}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mins  <= '0;
            r_maxs  <= '1;
            r_dz    <= '0;
            r_has_t <= 1'b0;
            r_has_r <= 1'b0;
            r_prev  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MINS:     r_mins  <= i_cfg_data;
                    REG_MAXS:     r_maxs  <= i_cfg_data;
                    REG_DZ:       r_dz    <= i_cfg_data[DZ_W-1:0];
                    REG_THROTTLE: r_has_t <= i_cfg_data[0];
                    REG_RUDDER:   r_has_r <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_load) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            if (r_state == S_IDLE && s_axis_tvalid && !r_ov && !s_axis_tdata[0]) begin
                r_olast <= 1'b1;
                r_okind <= KIND_AXES;
                r_odata <= '0;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_okind <= KIND_AXES;
                r_olast <= !w_more_start;
                r_odata <= {8'd0, r_res[3], r_res[2], r_res[1], r_res[0]};
                if (!w_more_start) r_prev <= w_cur_m;
            end
            if (r_state == S_SCAN && w_out_free) begin
                if (w_bchg) begin
                    r_okind <= w_bnow ? KIND_PRESS : KIND_RELEASE;
                    r_olast <= !w_more;
                    r_odata <= {3'd0, 5'(r_bi), 64'd0};
                end
                if (!w_more) r_prev <= w_cur_m;
            end
        end
        if (r_state == S_IDLE) begin
            r_pos <= s_axis_tdata[64:1];
            r_btn <= s_axis_tdata[96:65];
            r_ax  <= AX_X;
            r_bi  <= '0;
        end
        if (r_state == S_SCAN && w_out_free) r_bi <= r_bi + 1'b1;
        if (r_state == S_SETUP) begin
            if (w_an <= 0) r_mag <= ONE;
            else r_mag <= ONEM;
            r_neg <= (w_an <= 0);
            // default result for an absent axis or a zero span
            r_res[r_ax] <= '0;
        end
        if (r_state == S_DIV1 && w_rsp.done) begin
            r_mag <= w_absv;
            r_neg <= w_v[17];
        end
        if (r_state == S_DZ) begin
            if (r_ax == AX_Z) begin
                // throttle is the negated value, +ONE saturates
                r_res[r_ax] <= r_neg ? ((r_mag >= ONE) ? OUT_W'(ONEM) : OUT_W'(r_mag))
                                     : OUT_W'(-$signed({1'b0, r_mag}));
            end else if (r_mag < w_dzf) begin
                r_res[r_ax] <= '0;
            end
        end
        if (r_state == S_DIV2 && w_rsp.done) r_res[r_ax] <= OUT_W'(w_dz_res);
        if (r_state == S_AXOUT) r_ax <= r_ax + 2'd1;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid)
        else $error("sample accepted with a result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
    a_axes_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_AXES) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("button event carries axis data");
`endif

endmodule
